### rtl/alucc_pkg.sv
package alucc_pkg;

    localparam logic [3:0] FN_MOV  = 4'd0;
    localparam logic [3:0] FN_ADD  = 4'd1;
    localparam logic [3:0] FN_ADC  = 4'd2;
    localparam logic [3:0] FN_ASL  = 4'd3;
    localparam logic [3:0] FN_ASR  = 4'd4;
    localparam logic [3:0] FN_ASH  = 4'd5;
    localparam logic [3:0] FN_ASHC = 4'd6;
    localparam logic [3:0] FN_CLR  = 4'd7;
    localparam logic [3:0] FN_TST  = 4'd8;
    localparam logic [3:0] FN_BR   = 4'd9;
    localparam logic [3:0] FN_BEQ  = 4'd10;
    localparam logic [3:0] FN_BNE  = 4'd11;
    localparam logic [3:0] FN_BPL  = 4'd12;
    localparam logic [3:0] FN_SOB  = 4'd13;

    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{n: 1'b0, z: 1'b0, v: 1'b0, c: 1'b0};
    localparam flags_t FLAGS_CLEAR = '{n: 1'b0, z: 1'b1, v: 1'b0, c: 1'b0};

    typedef struct packed {
        logic [3:0]         func;
        logic               byte_mode;
        logic [15:0]        src_value;
        logic [15:0]        dst_value;
        logic [15:0]        dst_low_value;
        logic [15:0]        pc_value;
        logic signed [7:0]  branch_offset;
        logic [5:0]         loop_back;
    } in_item_t;

    typedef struct packed {
        logic [15:0] result;
        logic [15:0] result_low;
        logic        write_back;
        flags_t      flags;
        logic [15:0] next_pc;
        logic        branch_taken;
    } out_item_t;

endpackage

### rtl/alucc_instr_if.sv
interface alucc_instr_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic               byte_mode;
    logic [15:0]        src_value;
    logic [15:0]        dst_value;
    logic [15:0]        dst_low_value;
    logic [15:0]        pc_value;
    logic signed [7:0]  branch_offset;
    logic [5:0]         loop_back;

    modport source (
        output valid, func, byte_mode, src_value, dst_value, dst_low_value,
               pc_value, branch_offset, loop_back,
        input  ready
    );

    modport sink (
        input  valid, func, byte_mode, src_value, dst_value, dst_low_value,
               pc_value, branch_offset, loop_back,
        output ready
    );
endinterface

### rtl/alucc_outcome_if.sv
interface alucc_outcome_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [15:0] result_low;
    logic        write_back;
    logic        flag_neg;
    logic        flag_zero;
    logic        flag_ovf;
    logic        flag_carry;
    logic [15:0] next_pc;
    logic        branch_taken;

    modport source (
        output valid, result, result_low, write_back, flag_neg, flag_zero,
               flag_ovf, flag_carry, next_pc, branch_taken,
        input  ready
    );

    modport sink (
        input  valid, result, result_low, write_back, flag_neg, flag_zero,
               flag_ovf, flag_carry, next_pc, branch_taken,
        output ready
    );
endinterface

### rtl/alu_with_condition_codes.sv
// Execute stage for a 16-bit minicomputer subset with N, Z, V, C flags.
// instr (valid/ready) carries one operation with its operands, program
// counter and branch offsets; outcome (valid/ready) returns the write-back
// word, the low word of a double shift, the updated flags and the next PC
// with a taken bit. A transfer happens when valid and ready are both high.
// Every instruction gives exactly one outcome, in order.
// An instr transfer loads the input register; the ALU and flag logic then
// feed the outcome register. The condition-code register updates as an
// item enters the outcome register, so a dependent branch may follow in
// the very next cycle; throughput is one item per cycle while the receiver
// keeps outcome.ready high.
// When the receiver stalls, the outcome register holds and the input
// register still takes one more item; after that instr.ready drops until
// outcome moves again.
// Reset (rst_n low) empties both registers and clears all four flags.
module alu_with_condition_codes
    import alucc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    alucc_instr_if.sink     instr,
    alucc_outcome_if.source outcome
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    out_item_t out_reg;
    out_item_t out_next;
    flags_t    flags_reg;
    in_item_t  in_item;
    logic      in_fire;
    logic      s2_free;
    logic      s1_adv;

    assign in_item = '{
        func:          instr.func,
        byte_mode:     instr.byte_mode,
        src_value:     instr.src_value,
        dst_value:     instr.dst_value,
        dst_low_value: instr.dst_low_value,
        pc_value:      instr.pc_value,
        branch_offset: instr.branch_offset,
        loop_back:     instr.loop_back
    };

    assign s2_free     = !s2_valid_reg || outcome.ready;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign instr.ready = !s1_valid_reg || s2_free;
    assign in_fire     = instr.valid && instr.ready;

    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_adv);
    assign s2_valid_next = s1_adv || (s2_valid_reg && !outcome.ready);

    alucc_exec u_exec (
        .item  (s1_item_reg),
        .flags (flags_reg),
        .rsp   (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            flags_reg    <= FLAGS_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            // commit flags as the item leaves the input register
            if (s1_adv)
            begin
                flags_reg <= out_next.flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign outcome.valid        = s2_valid_reg;
    assign outcome.result       = out_reg.result;
    assign outcome.result_low   = out_reg.result_low;
    assign outcome.write_back   = out_reg.write_back;
    assign outcome.flag_neg     = out_reg.flags.n;
    assign outcome.flag_zero    = out_reg.flags.z;
    assign outcome.flag_ovf     = out_reg.flags.v;
    assign outcome.flag_carry   = out_reg.flags.c;
    assign outcome.next_pc      = out_reg.next_pc;
    assign outcome.branch_taken = out_reg.branch_taken;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !instr.ready |-> (s1_valid_reg && s2_valid_reg && !outcome.ready))
        else $error("instr stalled while a register was free");

    a_clr_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_item_reg.func == FN_CLR) |=>
        (outcome.valid && !outcome.flag_neg && outcome.flag_zero
         && !outcome.flag_ovf && !outcome.flag_carry))
        else $error("clr did not leave standard flags");

    a_branch_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_item_reg.func == FN_BR || s1_item_reg.func == FN_BEQ
                    || s1_item_reg.func == FN_BNE || s1_item_reg.func == FN_BPL
                    || s1_item_reg.func == FN_SOB))
        |=> (flags_reg == $past(flags_reg)))
        else $error("branch changed condition codes");

    a_no_wb_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (outcome.valid && !outcome.write_back) |-> (outcome.result == 16'd0))
        else $error("result nonzero without write-back");
`endif

endmodule

### rtl/alucc_exec.sv
module alucc_exec
    import alucc_pkg::*;
(
    input  in_item_t  item,
    input  flags_t    flags,
    output out_item_t rsp
);

    logic [15:0]        src;
    logic [15:0]        dst;
    logic [5:0]         cnt;
    logic [5:0]         rsh_amt;
    logic [31:0]        ash_left;
    logic signed [32:0] ash_right;
    logic [31:0]        ashc_old;
    logic [32:0]        ashc_left;
    logic signed [32:0] ashc_right;
    logic [16:0]        add_sum;
    logic [8:0]         adc_byte;
    logic [16:0]        adc_word;
    logic [15:0]        target_br;
    logic [15:0]        target_sob;
    logic [15:0]        sob_cnt;
    logic [7:0]         sh_byte;
    logic [15:0]        sh_word;
    logic               sh_c;
    logic [15:0]        ash_r;
    logic               ash_c;
    logic               ash_v;
    logic [31:0]        ashc_r;
    logic               ashc_c;
    logic               ashc_v;

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    assign src        = item.src_value;
    assign dst        = item.dst_value;
    assign cnt        = src[5:0];
    assign rsh_amt    = 6'd0 - cnt;
    assign ash_left   = {16'd0, dst} << cnt[4:0];
    assign ash_right  = $signed({{16{dst[15]}}, dst, 1'b0}) >>> rsh_amt;
    assign ashc_old   = {dst, item.dst_low_value};
    assign ashc_left  = {1'b0, ashc_old} << cnt[4:0];
    assign ashc_right = $signed({ashc_old, 1'b0}) >>> rsh_amt;
    assign add_sum    = {1'b0, src} + {1'b0, dst};
    assign adc_byte   = {1'b0, dst[7:0]} + {8'd0, flags.c};
    assign adc_word   = {1'b0, dst} + {16'd0, flags.c};
    assign sob_cnt    = dst - 16'd1;
    assign target_br  = item.pc_value
                        + {{7{item.branch_offset[7]}}, item.branch_offset, 1'b0};
    assign target_sob = item.pc_value - {9'd0, item.loop_back, 1'b0};

    // single-bit shifts for asl / asr
    always_comb
    begin
        if (item.func == FN_ASL)
        begin
            sh_byte = {dst[6:0], 1'b0};
            sh_word = {dst[14:0], 1'b0};
            sh_c    = item.byte_mode ? dst[7] : dst[15];
        end
        else
        begin
            sh_byte = {dst[7], dst[7:1]};
            sh_word = {dst[15], dst[15:1]};
            sh_c    = dst[0];
        end
    end

    // ash: counts above 16 to the left give zero
    always_comb
    begin
        ash_r = dst;
        ash_c = 1'b0;
        ash_v = 1'b0;
        if (cnt != 6'd0 && !cnt[5])
        begin
            if (cnt <= 6'd16)
            begin
                ash_r = ash_left[15:0];
                ash_c = ash_left[16];
                ash_v = ash_left[15] ^ dst[15];
            end
            else
            begin
                ash_r = 16'd0;
                ash_v = |dst;
            end
        end
        else if (cnt != 6'd0)
        begin
            ash_r = ash_right[16:1];
            ash_c = ash_right[0];
        end
    end

    always_comb
    begin
        ashc_r = ashc_old;
        ashc_c = 1'b0;
        ashc_v = 1'b0;
        if (cnt != 6'd0 && !cnt[5])
        begin
            ashc_r = ashc_left[31:0];
            ashc_c = ashc_left[32];
            ashc_v = ashc_left[31] ^ ashc_old[31];
        end
        else if (cnt != 6'd0)
        begin
            ashc_r = ashc_right[32:1];
            ashc_c = ashc_right[0];
        end
    end

    always_comb
    begin
        rsp.result       = 16'd0;
        rsp.result_low   = 16'd0;
        rsp.write_back   = 1'b0;
        rsp.flags        = flags;
        rsp.next_pc      = item.pc_value;
        rsp.branch_taken = 1'b0;

        case (item.func)
            FN_MOV:
            begin
                rsp.write_back = 1'b1;
                rsp.result     = item.byte_mode ? sext8(src[7:0]) : src;
                rsp.flags.n    = item.byte_mode ? src[7] : src[15];
                rsp.flags.z    = item.byte_mode ? (src[7:0] == 8'd0) : (src == 16'd0);
                rsp.flags.v    = 1'b0;
            end
            FN_ADD:
            begin
                rsp.write_back = 1'b1;
                rsp.result     = add_sum[15:0];
                rsp.flags.n    = add_sum[15];
                rsp.flags.z    = (add_sum[15:0] == 16'd0);
                rsp.flags.v    = (src[15] == dst[15]) && (add_sum[15] != src[15]);
                rsp.flags.c    = add_sum[16];
            end
            FN_ADC:
            begin
                rsp.write_back = 1'b1;
                if (item.byte_mode)
                begin
                    rsp.result  = sext8(adc_byte[7:0]);
                    rsp.flags.n = adc_byte[7];
                    rsp.flags.z = (adc_byte[7:0] == 8'd0);
                    rsp.flags.v = (dst[7:0] == 8'h7F) && flags.c;
                    rsp.flags.c = adc_byte[8];
                end
                else
                begin
                    rsp.result  = adc_word[15:0];
                    rsp.flags.n = adc_word[15];
                    rsp.flags.z = (adc_word[15:0] == 16'd0);
                    rsp.flags.v = (dst == 16'h7FFF) && flags.c;
                    rsp.flags.c = adc_word[16];
                end
            end
            FN_ASL, FN_ASR:
            begin
                rsp.write_back = 1'b1;
                rsp.flags.c    = sh_c;
                if (item.byte_mode)
                begin
                    rsp.result  = sext8(sh_byte);
                    rsp.flags.n = sh_byte[7];
                    rsp.flags.z = (sh_byte == 8'd0);
                    rsp.flags.v = sh_byte[7] ^ sh_c;
                end
                else
                begin
                    rsp.result  = sh_word;
                    rsp.flags.n = sh_word[15];
                    rsp.flags.z = (sh_word == 16'd0);
                    rsp.flags.v = sh_word[15] ^ sh_c;
                end
            end
            FN_ASH:
            begin
                rsp.write_back = 1'b1;
                rsp.result     = ash_r;
                rsp.flags.n    = ash_r[15];
                rsp.flags.z    = (ash_r == 16'd0);
                rsp.flags.v    = ash_v;
                rsp.flags.c    = ash_c;
            end
            FN_ASHC:
            begin
                rsp.write_back = 1'b1;
                rsp.result     = ashc_r[31:16];
                rsp.result_low = ashc_r[15:0];
                rsp.flags.n    = ashc_r[31];
                rsp.flags.z    = (ashc_r == 32'd0);
                rsp.flags.v    = ashc_v;
                rsp.flags.c    = ashc_c;
            end
            FN_CLR:
            begin
                rsp.write_back = 1'b1;
                rsp.flags      = FLAGS_CLEAR;
            end
            FN_TST:
            begin
                rsp.flags.n = item.byte_mode ? dst[7] : dst[15];
                rsp.flags.z = item.byte_mode ? (dst[7:0] == 8'd0) : (dst == 16'd0);
                rsp.flags.v = 1'b0;
                rsp.flags.c = 1'b0;
            end
            FN_BR:
            begin
                rsp.branch_taken = 1'b1;
                rsp.next_pc      = target_br;
            end
            FN_BEQ:
            begin
                rsp.branch_taken = flags.z;
                rsp.next_pc      = flags.z ? target_br : item.pc_value;
            end
            FN_BNE:
            begin
                rsp.branch_taken = !flags.z;
                rsp.next_pc      = flags.z ? item.pc_value : target_br;
            end
            FN_BPL:
            begin
                rsp.branch_taken = !flags.n;
                rsp.next_pc      = flags.n ? item.pc_value : target_br;
            end
            FN_SOB:
            begin
                rsp.write_back   = 1'b1;
                rsp.result       = sob_cnt;
                rsp.branch_taken = (sob_cnt != 16'd0);
                rsp.next_pc      = (sob_cnt != 16'd0) ? target_sob : item.pc_value;
            end
            default:
            begin
                rsp.result = 16'd0;
            end
        endcase
    end

endmodule

### tb/sv/alucc_outcome_checker.sv
`timescale 1ns / 1ps

module alucc_outcome_checker
    import alucc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    alucc_instr_if     instr,
    alucc_outcome_if   outcome,
    output int         fail_count,
    output int         pending_count
);

    flags_t    model_flags;
    out_item_t expected_outcomes[$];
    int        fails = 0;
    int        pending = 0;

    assign fail_count    = fails;
    assign pending_count = pending;

    // Execute one instruction against the model flags and return its outcome.
    function automatic out_item_t exec_instr(input in_item_t op);
        out_item_t   o;
        flags_t      f;
        logic [15:0] target;
        logic [15:0] r16;
        logic [16:0] sum17;
        logic [8:0]  sum9;
        logic [7:0]  w8;
        logic [7:0]  r8;
        logic [31:0] pair;
        logic [31:0] r32;
        logic [31:0] ext;
        logic        sign;
        logic        c;
        logic        v;
        logic        taken;
        int          amt;
        int          rsh;

        o      = '0;
        f      = model_flags;
        taken  = 1'b0;
        target = op.pc_value + {{7{op.branch_offset[7]}}, op.branch_offset, 1'b0};
        amt    = int'(op.src_value[5:0]);

        case (op.func)
            FN_MOV:
            begin
                if (op.byte_mode)
                begin
                    o.result = {{8{op.src_value[7]}}, op.src_value[7:0]};
                    f.n = op.src_value[7];
                    f.z = (op.src_value[7:0] == 8'h00);
                end
                else
                begin
                    o.result = op.src_value;
                    f.n = op.src_value[15];
                    f.z = (op.src_value == 16'h0000);
                end
                f.v = 1'b0;
                o.write_back = 1'b1;
            end
            FN_ADD:
            begin
                sum17 = {1'b0, op.src_value} + {1'b0, op.dst_value};
                r16 = sum17[15:0];
                f.n = r16[15];
                f.z = (r16 == 16'h0000);
                f.v = (op.src_value[15] == op.dst_value[15]) && (r16[15] != op.src_value[15]);
                f.c = sum17[16];
                o.result = r16;
                o.write_back = 1'b1;
            end
            FN_ADC:
            begin
                if (op.byte_mode)
                begin
                    sum9 = {1'b0, op.dst_value[7:0]} + {8'h00, model_flags.c};
                    o.result = {{8{sum9[7]}}, sum9[7:0]};
                    f.n = sum9[7];
                    f.z = (sum9[7:0] == 8'h00);
                    f.v = (op.dst_value[7:0] == 8'h7F) && model_flags.c;
                    f.c = sum9[8];
                end
                else
                begin
                    sum17 = {1'b0, op.dst_value} + {16'h0000, model_flags.c};
                    o.result = sum17[15:0];
                    f.n = sum17[15];
                    f.z = (sum17[15:0] == 16'h0000);
                    f.v = (op.dst_value == 16'h7FFF) && model_flags.c;
                    f.c = sum17[16];
                end
                o.write_back = 1'b1;
            end
            FN_ASL, FN_ASR:
            begin
                if (op.byte_mode)
                begin
                    w8 = op.dst_value[7:0];
                    if (op.func == FN_ASL)
                    begin
                        c  = w8[7];
                        r8 = {w8[6:0], 1'b0};
                    end
                    else
                    begin
                        c  = w8[0];
                        r8 = {w8[7], w8[7:1]};
                    end
                    f.n = r8[7];
                    f.z = (r8 == 8'h00);
                    o.result = {{8{r8[7]}}, r8};
                end
                else
                begin
                    if (op.func == FN_ASL)
                    begin
                        c   = op.dst_value[15];
                        r16 = {op.dst_value[14:0], 1'b0};
                    end
                    else
                    begin
                        c   = op.dst_value[0];
                        r16 = {op.dst_value[15], op.dst_value[15:1]};
                    end
                    f.n = r16[15];
                    f.z = (r16 == 16'h0000);
                    o.result = r16;
                end
                f.c = c;
                f.v = f.n ^ c;
                o.write_back = 1'b1;
            end
            FN_ASH:
            begin
                sign = op.dst_value[15];
                c    = 1'b0;
                v    = 1'b0;
                r16  = op.dst_value;
                if (amt != 0 && amt < 32)
                begin
                    if (amt <= 16)
                    begin
                        c   = op.dst_value[4'(16 - amt)];
                        r16 = op.dst_value << amt;
                        v   = r16[15] ^ op.dst_value[15];
                    end
                    else
                    begin
                        r16 = 16'h0000;
                        v   = (op.dst_value != 16'h0000);
                    end
                end
                else if (amt != 0)
                begin
                    rsh = 64 - amt;
                    if (rsh <= 16)
                    begin
                        ext = {{16{sign}}, op.dst_value};
                        c   = op.dst_value[4'(rsh - 1)];
                        r32 = ext >> rsh;
                        r16 = r32[15:0];
                    end
                    else
                    begin
                        r16 = {16{sign}};
                        c   = sign;
                    end
                end
                f.n = r16[15];
                f.z = (r16 == 16'h0000);
                f.v = v;
                f.c = c;
                o.result = r16;
                o.write_back = 1'b1;
            end
            FN_ASHC:
            begin
                pair = {op.dst_value, op.dst_low_value};
                sign = pair[31];
                c    = 1'b0;
                v    = 1'b0;
                r32  = pair;
                if (amt != 0 && amt < 32)
                begin
                    c   = pair[5'(32 - amt)];
                    r32 = pair << amt;
                    v   = r32[31] ^ pair[31];
                end
                else if (amt != 0)
                begin
                    rsh = 64 - amt;
                    c   = pair[5'(rsh - 1)];
                    r32 = pair >> rsh;
                    // fill vacated high bits with the sign, all 32 for a shift of 32
                    if (sign)
                        r32 = r32 | ~(32'hFFFF_FFFF >> rsh);
                end
                f.n = r32[31];
                f.z = (r32 == 32'h0000_0000);
                f.v = v;
                f.c = c;
                o.result = r32[31:16];
                o.result_low = r32[15:0];
                o.write_back = 1'b1;
            end
            FN_CLR:
            begin
                f = FLAGS_CLEAR;
                o.write_back = 1'b1;
            end
            FN_TST:
            begin
                if (op.byte_mode)
                begin
                    f.n = op.dst_value[7];
                    f.z = (op.dst_value[7:0] == 8'h00);
                end
                else
                begin
                    f.n = op.dst_value[15];
                    f.z = (op.dst_value == 16'h0000);
                end
                f.v = 1'b0;
                f.c = 1'b0;
            end
            FN_BR:  taken = 1'b1;
            FN_BEQ: taken = model_flags.z;
            FN_BNE: taken = !model_flags.z;
            FN_BPL: taken = !model_flags.n;
            FN_SOB:
            begin
                o.result = op.dst_value - 16'd1;
                o.write_back = 1'b1;
                if (o.result != 16'h0000)
                begin
                    taken  = 1'b1;
                    target = op.pc_value - {9'd0, op.loop_back, 1'b0};
                end
            end
            default:
            begin
            end
        endcase

        o.next_pc      = taken ? target : op.pc_value;
        o.branch_taken = taken;
        o.flags        = f;
        model_flags    = f;
        return o;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        in_item_t  op;
        out_item_t want;

        if (!rst_n)
        begin
            model_flags = FLAGS_RESET;
            expected_outcomes.delete();
        end
        else
        begin
            // compare first: an instruction taken at this edge cannot retire at it
            if (outcome.valid && outcome.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("outcome transfer with no instruction outstanding");
                    fails++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("result", want.result, outcome.result);
                    check_field("result_low", want.result_low, outcome.result_low);
                    check_field("write_back", 16'(want.write_back),
                                16'(outcome.write_back));
                    check_field("flag_neg", 16'(want.flags.n), 16'(outcome.flag_neg));
                    check_field("flag_zero", 16'(want.flags.z), 16'(outcome.flag_zero));
                    check_field("flag_ovf", 16'(want.flags.v), 16'(outcome.flag_ovf));
                    check_field("flag_carry", 16'(want.flags.c), 16'(outcome.flag_carry));
                    check_field("next_pc", want.next_pc, outcome.next_pc);
                    check_field("branch_taken", 16'(want.branch_taken),
                                16'(outcome.branch_taken));
                end
            end
            if (instr.valid && instr.ready)
            begin
                op.func          = instr.func;
                op.byte_mode     = instr.byte_mode;
                op.src_value     = instr.src_value;
                op.dst_value     = instr.dst_value;
                op.dst_low_value = instr.dst_low_value;
                op.pc_value      = instr.pc_value;
                op.branch_offset = instr.branch_offset;
                op.loop_back     = instr.loop_back;
                expected_outcomes.push_back(exec_instr(op));
            end
        end
        pending = expected_outcomes.size();
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import alucc_pkg::*;

    // codes the block decodes as no operation
    localparam logic [3:0] FN_NOP_A = 4'd14;
    localparam logic [3:0] FN_NOP_B = 4'd15;

    localparam int ITEMS_PER_PHASE = 400;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   fail_count;
    int   pending_count;

    logic [15:0] word_corners[8] = '{16'h0000, 16'h0001, 16'h007F, 16'h0080,
                                     16'h00FF, 16'h7FFF, 16'h8000, 16'hFFFF};
    logic [5:0]  count_corners[12] = '{6'd0, 6'd1, 6'd15, 6'd16, 6'd17, 6'd31,
                                       6'd32, 6'd33, 6'd47, 6'd48, 6'd49, 6'd63};

    alucc_instr_if   instr_ch();
    alucc_outcome_if outcome_ch();

    alu_with_condition_codes u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .instr   (instr_ch),
        .outcome (outcome_ch)
    );

    alucc_outcome_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .instr         (instr_ch),
        .outcome       (outcome_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        outcome_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [15:0] any_word();
        if ($urandom_range(3) == 0)
            return word_corners[3'($urandom_range(7))];
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic in_item_t mk_instr(input logic [3:0] fn, input logic bm,
                                          input logic [15:0] src, input logic [15:0] dst,
                                          input logic [15:0] dlow, input logic [15:0] pc,
                                          input logic [7:0] off, input logic [5:0] back);
        in_item_t it;
        it.func          = fn;
        it.byte_mode     = bm;
        it.src_value     = src;
        it.dst_value     = dst;
        it.dst_low_value = dlow;
        it.pc_value      = pc;
        it.branch_offset = off;
        it.loop_back     = back;
        return it;
    endfunction

    function automatic in_item_t random_instr();
        in_item_t it;
        if ($urandom_range(19) == 0)
            it.func = $urandom_range(1) ? FN_NOP_A : FN_NOP_B;
        else
            it.func = 4'($urandom_range(FN_SOB));
        it.byte_mode     = 1'($urandom_range(1));
        it.src_value     = any_word();
        if ((it.func == FN_ASH || it.func == FN_ASHC) && $urandom_range(1))
            it.src_value[5:0] = count_corners[4'($urandom_range(11))];
        it.dst_value     = any_word();
        it.dst_low_value = any_word();
        it.pc_value      = any_word();
        it.branch_offset = 8'($urandom_range(255));
        it.loop_back     = 6'($urandom_range(63));
        return it;
    endfunction

    // Hold the instruction on the channel until it transfers.
    task automatic send_instr(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            instr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        instr_ch.valid         <= 1'b1;
        instr_ch.func          <= it.func;
        instr_ch.byte_mode     <= it.byte_mode;
        instr_ch.src_value     <= it.src_value;
        instr_ch.dst_value     <= it.dst_value;
        instr_ch.dst_low_value <= it.dst_low_value;
        instr_ch.pc_value      <= it.pc_value;
        instr_ch.branch_offset <= it.branch_offset;
        instr_ch.loop_back     <= it.loop_back;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        #1ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n                  = 1'b0;
        instr_ch.valid         = 1'b0;
        instr_ch.func          = FN_MOV;
        instr_ch.byte_mode     = 1'b0;
        instr_ch.src_value     = '0;
        instr_ch.dst_value     = '0;
        instr_ch.dst_low_value = '0;
        instr_ch.pc_value      = '0;
        instr_ch.branch_offset = '0;
        instr_ch.loop_back     = '0;
        outcome_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                send_instr(mk_instr(FN_CLR, 1'b0, 16'h1234, 16'hABCD, 16'h0, 16'h0100, 8'h00, 6'd0));
                // Z set: branch back across address zero
                send_instr(mk_instr(FN_BEQ, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0004, 8'h80, 6'd0));
                send_instr(mk_instr(FN_BNE, 1'b1, 16'h0, 16'h0, 16'h0, 16'h2000, 8'h7F, 6'd0));
                send_instr(mk_instr(FN_MOV, 1'b1, 16'h1280, 16'h0, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ADD, 1'b0, 16'h7FFF, 16'h0001, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ADD, 1'b0, 16'hFFFF, 16'h0001, 16'h0, 16'h0, 8'h00, 6'd0));
                // carry in from the add above
                send_instr(mk_instr(FN_ADC, 1'b1, 16'h0, 16'hFF7F, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASL, 1'b0, 16'h0, 16'h8000, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ADC, 1'b0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ADC, 1'b0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASL, 1'b1, 16'h0, 16'h0040, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASR, 1'b0, 16'h0, 16'h8001, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASR, 1'b1, 16'h0, 16'h0081, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASH, 1'b0, 16'hFFC0, 16'h8000, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASH, 1'b0, 16'h0010, 16'h0001, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASH, 1'b0, 16'h0011, 16'h1234, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASH, 1'b0, 16'hFFFF, 16'h8001, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASH, 1'b0, 16'h0020, 16'h8000, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASHC, 1'b0, 16'h001F, 16'h0000, 16'h0003, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASHC, 1'b0, 16'h0020, 16'h8000, 16'h0001, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_ASHC, 1'b0, 16'h0021, 16'h4000, 16'h0000, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_TST, 1'b1, 16'h0, 16'hFF00, 16'h0, 16'h0, 8'h00, 6'd0));
                send_instr(mk_instr(FN_BPL, 1'b0, 16'h0, 16'h0, 16'h0, 16'h1000, 8'hF0, 6'd0));
                send_instr(mk_instr(FN_BR, 1'b0, 16'h0, 16'h0, 16'h0, 16'hFFFE, 8'h7F, 6'd0));
                send_instr(mk_instr(FN_SOB, 1'b0, 16'h0, 16'h0001, 16'h0, 16'h0400, 8'h00, 6'd5));
                send_instr(mk_instr(FN_SOB, 1'b0, 16'h0, 16'h0000, 16'h0, 16'h0000, 8'h00, 6'd63));
                send_instr(mk_instr(FN_NOP_A, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    8'hFF, 6'd63));
                send_instr(mk_instr(FN_NOP_B, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00, 6'd0));
            end

            repeat (ITEMS_PER_PHASE)
                send_instr(random_instr());
        end

        @(negedge clk);
        instr_ch.valid <= 1'b0;
        wait (pending_count == 0);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
